// ----- rtl/core/ccsf_pkg.sv -----
`timescale 1ns / 1ps

package ccsf_pkg;

  // Coordinate space: one table entry per column
  localparam int COORD_W     = 10;
  localparam int COORD_RANGE = 1 << COORD_W;
  localparam int SIZE_W      = COORD_W + 1;
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(COORD_RANGE - 1);

  // Command codes
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // One column table entry
  typedef struct packed {
    logic               used;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_y;
  } col_entry_t;

  // Bounding box of all pixels added since the last clear
  typedef struct packed {
    logic               any;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] bottom;
  } box_t;

endpackage

// ----- rtl/core/ccsf_col_mem.sv -----
`timescale 1ns / 1ps

// Column table: single write port, one registered read port with
// write-to-read bypass, and a zeroing sweep after reset or clear.
module ccsf_col_mem
  import ccsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [COORD_W-1:0] rd_addr,
  output col_entry_t         rd_data,
  input  logic               wr_en,
  input  logic [COORD_W-1:0] wr_addr,
  input  col_entry_t         wr_data,
  input  logic               clear_start,
  output logic               busy
);

  col_entry_t         mem [COORD_RANGE];
  logic               sweeping;
  logic [COORD_W-1:0] sweep_addr;

  assign busy = sweeping;

  // Sweep control: one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (clear_start) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (sweeping) begin
      sweep_addr <= sweep_addr + COORD_W'(1);
      if (sweep_addr == COORD_MAX) begin
        sweeping <= 1'b0;
      end
    end
  end

  // Write port: sweep has priority, no transactions run during it
  always_ff @(posedge clk) begin
    if (sweeping) begin
      mem[sweep_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, bypassing a write to the same column in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && !sweeping && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ----- rtl/core/ccsf_box.sv -----
`timescale 1ns / 1ps

// Bounding box tracker: a clear resets the box; independent min and max tests on every add.
module ccsf_box
  import ccsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               update,
  input  logic [1:0]         cmd,
  input  logic               add_ok,
  input  logic [COORD_W-1:0] x,
  input  logic [COORD_W-1:0] y,
  output box_t               box
);

  box_t box_next;

  always_comb begin
    box_next = box;
    if (update && (cmd == CMD_CLEAR)) begin
      box_next.any    = 1'b0;
      box_next.left   = COORD_MAX;
      box_next.right  = '0;
      box_next.top    = COORD_MAX;
      box_next.bottom = '0;
    end else if (update && (cmd == CMD_ADD) && add_ok) begin
      box_next.any = 1'b1;
      if (x < box.left)   box_next.left   = x;
      if (x > box.right)  box_next.right  = x;
      if (y < box.top)    box_next.top    = y;
      if (y > box.bottom) box_next.bottom = y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box.any    <= 1'b0;
      box.left   <= COORD_MAX;
      box.right  <= '0;
      box.top    <= COORD_MAX;
      box.bottom <= '0;
    end else begin
      box <= box_next;
    end
  end

endmodule

// ----- rtl/core/contour_column_span_fill_top.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// item      item_valid / item_ready      cmd, pixel_x, pixel_y, query_column
// result    result_valid / result_ready  column_has_pixels, span_top, span_bottom,
//                                        mask_width, mask_height
//
// One transaction per cycle while no sweep runs and no result is stalled:
// input register, column table read, update or result register.
// Add and clear give no result; a column table read-modify-write per add is
// bypassed so back-to-back adds to one column are seen in order.
// After reset and after each clear the table is zeroed one column a cycle:
// item_ready stays low during the sweep after reset, and from acceptance of a
// clear until its sweep is done (1024-column sweep).
// A stalled result holds its stage; earlier stages keep filling behind it.
module contour_column_span_fill_top
  import ccsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         cmd,
  input  logic [COORD_W-1:0] pixel_x,
  input  logic [COORD_W-1:0] pixel_y,
  input  logic [COORD_W-1:0] query_column,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               column_has_pixels,
  output logic [COORD_W-1:0] span_top,
  output logic [COORD_W-1:0] span_bottom,
  output logic [SIZE_W-1:0]  mask_width,
  output logic [SIZE_W-1:0]  mask_height
);

  // Stage 1: input register
  logic               s1_valid;
  logic [1:0]         s1_cmd;
  logic [COORD_W-1:0] s1_x;
  logic [COORD_W-1:0] s1_y;
  logic [COORD_W-1:0] s1_qc;

  // Stage 2: table data arrives
  logic               s2_valid;
  logic [1:0]         s2_cmd;
  logic               s2_ok;
  logic [COORD_W-1:0] s2_addr;
  logic [COORD_W-1:0] s2_y;
  logic [COORD_W-1:0] s2_top;
  logic [SIZE_W-1:0]  s2_w;
  logic [SIZE_W-1:0]  s2_h;

  logic               out_free;
  logic               s2_adv;
  logic               s2_free;
  logic               s1_adv;
  logic               accept;
  logic               block;
  logic               mem_busy;

  box_t               box;
  logic               add_ok;
  logic [SIZE_W-1:0]  q_col;
  logic               q_ok;
  logic [SIZE_W-1:0]  box_w;
  logic [SIZE_W-1:0]  box_h;
  logic [COORD_W-1:0] rd_addr;
  col_entry_t         rd_data;
  col_entry_t         wr_data;
  logic               wr_en;
  logic               res_has;

  // Flow control
  assign out_free   = !result_valid || result_ready;
  assign s2_adv     = s2_valid && ((s2_cmd != CMD_QUERY) || out_free);
  assign s2_free    = !s2_valid || s2_adv;
  assign s1_adv     = s1_valid && s2_free;
  assign block      = mem_busy || (s1_valid && (s1_cmd == CMD_CLEAR))
                      || (s2_valid && (s2_cmd == CMD_CLEAR));
  assign item_ready = !block && (!s1_valid || s2_free);
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= cmd;
      s1_x   <= pixel_x;
      s1_y   <= pixel_y;
      s1_qc  <= query_column;
    end
  end

  // Stage 1 decode: range check, query column and box size
  assign add_ok = (32'(s1_x) < COORD_RANGE) && (32'(s1_y) < COORD_RANGE);
  assign q_col  = {1'b0, box.left} + {1'b0, s1_qc};
  assign q_ok   = box.any && (q_col <= {1'b0, box.right});
  assign box_w  = box.any ? ({1'b0, box.right} - {1'b0, box.left} + SIZE_W'(1)) : '0;
  assign box_h  = box.any ? ({1'b0, box.bottom} - {1'b0, box.top} + SIZE_W'(1)) : '0;
  assign rd_addr = (s1_cmd == CMD_ADD) ? s1_x : q_col[COORD_W-1:0];

  ccsf_box u_box (
    .clk    (clk),
    .rst    (rst),
    .update (s1_adv),
    .cmd    (s1_cmd),
    .add_ok (add_ok),
    .x      (s1_x),
    .y      (s1_y),
    .box    (box)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_cmd  <= s1_cmd;
      s2_ok   <= (s1_cmd == CMD_ADD) ? add_ok : q_ok;
      s2_addr <= rd_addr;
      s2_y    <= s1_y;
      s2_top  <= box.top;
      s2_w    <= box_w;
      s2_h    <= box_h;
    end
  end

  // Stage 2: column update for an add
  always_comb begin
    wr_data.used  = 1'b1;
    wr_data.min_y = s2_y;
    wr_data.max_y = s2_y;
    if (rd_data.used) begin
      if (rd_data.min_y < s2_y) wr_data.min_y = rd_data.min_y;
      if (rd_data.max_y > s2_y) wr_data.max_y = rd_data.max_y;
    end
  end

  assign wr_en = s2_adv && (s2_cmd == CMD_ADD) && s2_ok;

  ccsf_col_mem u_col_mem (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (s1_adv),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (s2_addr),
    .wr_data     (wr_data),
    .clear_start (s2_valid && (s2_cmd == CMD_CLEAR)),
    .busy        (mem_busy)
  );

  // Stage 2: query result into the output register
  assign res_has = s2_ok && rd_data.used;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_adv && (s2_cmd == CMD_QUERY)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && (s2_cmd == CMD_QUERY)) begin
      column_has_pixels <= res_has;
      span_top          <= res_has ? (rd_data.min_y - s2_top) : '0;
      span_bottom       <= res_has ? (rd_data.max_y - s2_top) : '0;
      mask_width        <= s2_w;
      mask_height       <= s2_h;
    end
  end

endmodule

// ----- rtl/core/ccsf_checker.sv -----
`timescale 1ns / 1ps

// Port-level checks on the top level.
module ccsf_checker
  import ccsf_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic [1:0]         cmd,
  input logic               result_valid,
  input logic               result_ready,
  input logic               column_has_pixels,
  input logic [COORD_W-1:0] span_top,
  input logic [COORD_W-1:0] span_bottom,
  input logic [SIZE_W-1:0]  mask_width,
  input logic [SIZE_W-1:0]  mask_height
);

  // Table sweep runs straight after reset
  a_ready_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !item_ready)
    else $error("item_ready high during post-reset sweep");

  // A clear transaction blocks the next one
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && (cmd == CMD_CLEAR)) |=> !item_ready)
    else $error("transaction accepted right after clear");

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(span_top) && $stable(span_bottom)
       && $stable(mask_width) && $stable(column_has_pixels)))
    else $error("stalled result changed");

  // Empty box gives an all-zero result
  a_empty_box: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (mask_width == '0)) |->
      (!column_has_pixels && (span_top == '0) && (span_bottom == '0)
       && (mask_height == '0)))
    else $error("non-zero result for empty box");

  // A filled span is ordered and lies inside the box
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && column_has_pixels) |->
      ((span_top <= span_bottom) && ({1'b0, span_bottom} < mask_height)))
    else $error("span out of order or outside box");

endmodule

bind contour_column_span_fill_top ccsf_checker u_ccsf_checker (.*);
